// File: src/xtt_pkg.sv
// ============================================================================
// xtt_pkg
// Shared types, character constants and character-class helpers for the
// markup tag tokenizer.
// ============================================================================
`default_nettype none

package xtt_pkg;

   // Event kinds carried on the result channel
   localparam logic [2:0] EV_START = 3'd0;
   localparam logic [2:0] EV_END   = 3'd1;
   localparam logic [2:0] EV_ATTR  = 3'd2;
   localparam logic [2:0] EV_ERROR = 3'd3;
   localparam logic [2:0] EV_DONE  = 3'd4;

   // Markup characters
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_DQ    = 8'h22;
   localparam logic [7:0] CH_SQ    = 8'h27;
   localparam logic [7:0] CH_CTRL  = 8'h20;

   // Event queue between parser and output stage
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // One result event
   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] name_offset;
      logic [15:0] name_length;
      logic [15:0] value_offset;
      logic [15:0] value_length;
   } xtt_event_type;

   // All events caused by one byte (one or two)
   typedef struct packed {
      logic          second;
      xtt_event_type ev0;
      xtt_event_type ev1;
   } xtt_rec_type;

   // Queue status seen by the output stage
   typedef struct packed {
      logic empty;
      logic full;
   } xtt_qstat_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'd9) || (c == 8'd10) || (c == 8'd13) || (c == 8'd32);
   endfunction

   function automatic logic is_name_first(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || (c == 8'h5F);
   endfunction

   function automatic logic is_name_more(input logic [7:0] c);
      return is_name_first(c) || (c >= 8'h30 && c <= 8'h39) || (c == 8'h2D) ||
             (c == 8'h2E);
   endfunction

endpackage

`default_nettype wire

// File: src/xtt_front.sv
// ============================================================================
// xtt_front
// Byte parser: accepts one document byte per transfer, advances the tag
// state machine and packs the one or two events the byte causes.
// ============================================================================
`default_nettype none

module xtt_front #(
   parameter int OFFSET_BITS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic                start_of_document,
   input  wire logic [7:0]          char_byte,
   output      logic                push,
   output      xtt_pkg::xtt_rec_type rec
);
   import xtt_pkg::*;

   // Parser modes
   localparam logic [3:0] M_HALTED     = 4'd0;
   localparam logic [3:0] M_ROOT       = 4'd1;
   localparam logic [3:0] M_TAG        = 4'd2;
   localparam logic [3:0] M_NAME       = 4'd3;
   localparam logic [3:0] M_TAG_CLOSE  = 4'd4;
   localparam logic [3:0] M_ELEM_END   = 4'd5;
   localparam logic [3:0] M_ATTRIB     = 4'd6;
   localparam logic [3:0] M_ATTRIB_EQ  = 4'd7;
   localparam logic [3:0] M_VAL_BEGIN  = 4'd8;
   localparam logic [3:0] M_VAL_SINGLE = 4'd9;
   localparam logic [3:0] M_VAL_DOUBLE = 4'd10;

   // Name kinds
   localparam logic [1:0] K_START = 2'd0;
   localparam logic [1:0] K_END   = 2'd1;
   localparam logic [1:0] K_ATTR  = 2'd2;

   localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;
   localparam logic [OFFSET_BITS-1:0] POS_ONE = OFFSET_BITS'(1);

   logic [3:0]             mode_ff, mode_in;
   logic [1:0]             kind_ff, kind_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] tag_start_ff, tag_start_in;
   logic [OFFSET_BITS-1:0] tag_len_ff, tag_len_in;
   logic [OFFSET_BITS-1:0] an_start_ff, an_start_in;
   logic [OFFSET_BITS-1:0] an_len_ff, an_len_in;
   logic [OFFSET_BITS-1:0] val_start_ff, val_start_in;

   logic [OFFSET_BITS-1:0] p;
   logic                   redo;
   logic                   emit;
   logic [1:0]             n_ev;
   xtt_event_type          ev;

   // Fit an offset into the 16-bit result fields
   function automatic logic [15:0] to16(input logic [OFFSET_BITS-1:0] x);
      logic [31:0] w;
      w = 32'(x);
      return w[15:0];
   endfunction

   function automatic xtt_event_type make_ev(
      input logic [2:0]  k,
      input logic [15:0] no,
      input logic [15:0] nl,
      input logic [15:0] vo,
      input logic [15:0] vl
   );
      xtt_event_type e;
      e.kind         = k;
      e.name_offset  = no;
      e.name_length  = nl;
      e.value_offset = vo;
      e.value_length = vl;
      return e;
   endfunction

   // Parse one byte; a byte that ends a name is examined a second time
   always_comb begin
      mode_in      = mode_ff;
      kind_in      = kind_ff;
      pos_in       = pos_ff;
      tag_start_in = tag_start_ff;
      tag_len_in   = tag_len_ff;
      an_start_in  = an_start_ff;
      an_len_in    = an_len_ff;
      val_start_in = val_start_ff;
      rec          = '0;
      n_ev         = '0;
      redo         = 1'b0;
      emit         = 1'b0;
      ev           = '0;
      p            = '0;
      if (accept) begin
         if (start_of_document) begin
            mode_in      = M_ROOT;
            kind_in      = K_START;
            pos_in       = '0;
            tag_start_in = '0;
            tag_len_in   = '0;
            an_start_in  = '0;
            an_len_in    = '0;
            val_start_in = '0;
         end
         if (mode_in != M_HALTED) begin
            p = pos_in;
            if (p == POS_MAX) begin
               rec.ev0 = make_ev(EV_ERROR, 16'd0, 16'd0, to16(p), 16'd1);
               n_ev    = 2'd1;
               mode_in = M_HALTED;
            end else begin
               for (int pass = 0; pass < 2; pass++) begin
                  if (pass == 0 || redo) begin
                     redo = 1'b0;
                     emit = 1'b0;
                     ev   = make_ev(EV_ERROR, 16'd0, 16'd0, to16(p), 16'd1);
                     case (mode_in)
                        M_ROOT: begin
                           if (char_byte == CH_NUL) begin
                              ev      = make_ev(EV_DONE, 16'd0, 16'd0, 16'd0, 16'd0);
                              emit    = 1'b1;
                              mode_in = M_HALTED;
                           end else if (char_byte == CH_LT) begin
                              mode_in = M_TAG;
                           end else if (!is_space(char_byte)) begin
                              emit    = 1'b1;
                              mode_in = M_HALTED;
                           end
                        end
                        M_TAG: begin
                           if (char_byte == CH_SLASH) begin
                              mode_in = M_ELEM_END;
                           end else if (is_name_first(char_byte)) begin
                              tag_start_in = p;
                              kind_in      = K_START;
                              mode_in      = M_NAME;
                           end else if (!is_space(char_byte)) begin
                              emit    = 1'b1;
                              mode_in = M_HALTED;
                           end
                        end
                        M_ELEM_END: begin
                           if (is_name_first(char_byte)) begin
                              tag_start_in = p;
                              kind_in      = K_END;
                              mode_in      = M_NAME;
                           end else if (!is_space(char_byte)) begin
                              emit    = 1'b1;
                              mode_in = M_HALTED;
                           end
                        end
                        M_NAME: begin
                           if (!is_name_more(char_byte)) begin
                              redo = 1'b1;
                              if (kind_in == K_START) begin
                                 tag_len_in = p - tag_start_in;
                                 ev = make_ev(EV_START, to16(tag_start_in),
                                              to16(tag_len_in), 16'd0, 16'd0);
                                 emit    = 1'b1;
                                 mode_in = M_ATTRIB;
                              end else if (kind_in == K_END) begin
                                 tag_len_in = p - tag_start_in;
                                 ev = make_ev(EV_END, to16(tag_start_in),
                                              to16(tag_len_in), 16'd0, 16'd0);
                                 emit    = 1'b1;
                                 mode_in = M_TAG_CLOSE;
                              end else begin
                                 an_len_in = p - an_start_in;
                                 mode_in   = M_ATTRIB_EQ;
                              end
                           end
                        end
                        M_TAG_CLOSE: begin
                           if (char_byte == CH_GT) begin
                              mode_in = M_ROOT;
                           end else begin
                              emit    = 1'b1;
                              mode_in = M_HALTED;
                           end
                        end
                        M_ATTRIB: begin
                           if (char_byte == CH_SLASH) begin
                              ev = make_ev(EV_END, to16(tag_start_in), to16(tag_len_in),
                                           16'd0, 16'd0);
                              emit    = 1'b1;
                              mode_in = M_TAG_CLOSE;
                           end else if (char_byte == CH_GT) begin
                              mode_in = M_ROOT;
                           end else if (is_name_first(char_byte)) begin
                              an_start_in = p;
                              kind_in     = K_ATTR;
                              mode_in     = M_NAME;
                           end else if (!is_space(char_byte)) begin
                              emit    = 1'b1;
                              mode_in = M_HALTED;
                           end
                        end
                        M_ATTRIB_EQ: begin
                           if (char_byte == CH_EQ) begin
                              mode_in = M_VAL_BEGIN;
                           end else if (!is_space(char_byte)) begin
                              emit    = 1'b1;
                              mode_in = M_HALTED;
                           end
                        end
                        M_VAL_BEGIN: begin
                           if (char_byte == CH_DQ || char_byte == CH_SQ) begin
                              val_start_in = p + POS_ONE;
                              mode_in = (char_byte == CH_DQ) ? M_VAL_DOUBLE : M_VAL_SINGLE;
                           end else if (!is_space(char_byte)) begin
                              emit    = 1'b1;
                              mode_in = M_HALTED;
                           end
                        end
                        M_VAL_SINGLE, M_VAL_DOUBLE: begin
                           if (char_byte < CH_CTRL) begin
                              emit    = 1'b1;
                              mode_in = M_HALTED;
                           end else if ((mode_in == M_VAL_SINGLE && char_byte == CH_SQ) ||
                                        (mode_in == M_VAL_DOUBLE && char_byte == CH_DQ)) begin
                              ev = make_ev(EV_ATTR, to16(an_start_in), to16(an_len_in),
                                           to16(val_start_in), to16(p - val_start_in));
                              emit    = 1'b1;
                              mode_in = M_ATTRIB;
                           end
                        end
                        default: begin
                           mode_in = M_HALTED;
                        end
                     endcase
                     // Place the event in the next free slot
                     if (emit) begin
                        if (n_ev == 2'd0) begin
                           rec.ev0 = ev;
                        end else begin
                           rec.ev1 = ev;
                        end
                        n_ev = n_ev + 2'd1;
                     end
                  end
               end
            end
            if (mode_in != M_HALTED) begin
               pos_in = p + POS_ONE;
            end
         end
      end
      rec.second = (n_ev == 2'd2);
   end

   assign push = accept && (n_ev != 2'd0);

   // Hold parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= M_HALTED;
         kind_ff      <= K_START;
         pos_ff       <= '0;
         tag_start_ff <= '0;
         tag_len_ff   <= '0;
         an_start_ff  <= '0;
         an_len_ff    <= '0;
         val_start_ff <= '0;
      end else begin
         mode_ff      <= mode_in;
         kind_ff      <= kind_in;
         pos_ff       <= pos_in;
         tag_start_ff <= tag_start_in;
         tag_len_ff   <= tag_len_in;
         an_start_ff  <= an_start_in;
         an_len_ff    <= an_len_in;
         val_start_ff <= val_start_in;
      end
   end

endmodule

`default_nettype wire

// File: src/xtt_queue.sv
// ============================================================================
// xtt_queue
// Short queue of per-byte event records between the parser and the
// output stage.
// ============================================================================
`default_nettype none

module xtt_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire xtt_pkg::xtt_rec_type  push_rec,
   input  wire logic                  pop,
   output      xtt_pkg::xtt_rec_type  head_rec,
   output      xtt_pkg::xtt_qstat_type status
);
   import xtt_pkg::*;

   localparam logic [QCNT_BITS-1:0] CNT_FULL = QCNT_BITS'(QUEUE_DEPTH);
   localparam logic [QCNT_BITS-1:0] CNT_ONE  = QCNT_BITS'(1);
   localparam logic [QPTR_BITS-1:0] PTR_ONE  = QPTR_BITS'(1);

   xtt_rec_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_FULL);
   assign head_rec     = mem_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_ONE : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_ONE : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_ONE;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store records
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("event queue occupancy beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      status.full |-> !push)
      else $error("record pushed into full event queue");

endmodule

`default_nettype wire

// File: src/xtt_back.sv
// ============================================================================
// xtt_back
// Output stage: drains event records from the queue and presents one event
// per transfer in an output register, marking the last event of each byte.
// ============================================================================
`default_nettype none

module xtt_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire xtt_pkg::xtt_rec_type   head_rec,
   input  wire xtt_pkg::xtt_qstat_type status,
   output      logic                   pop,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      logic [2:0]             rsp_event_kind,
   output      logic [15:0]            rsp_name_offset,
   output      logic [15:0]            rsp_name_length,
   output      logic [15:0]            rsp_value_offset,
   output      logic [15:0]            rsp_value_length,
   output      logic                   rsp_last_of_run
);
   import xtt_pkg::*;

   logic          valid_ff, valid_in;
   logic          pending_ff, pending_in;
   xtt_event_type out_ff, out_in;
   logic          last_ff, last_in;
   xtt_event_type sec_ff, sec_in;
   logic          out_free;

   assign out_free = !valid_ff || !rsp_stall;

   // Load the output register from the held second event or the queue head
   always_comb begin
      valid_in   = valid_ff;
      pending_in = pending_ff;
      out_in     = out_ff;
      last_in    = last_ff;
      sec_in     = sec_ff;
      pop        = 1'b0;
      if (out_free) begin
         if (pending_ff) begin
            valid_in   = 1'b1;
            out_in     = sec_ff;
            last_in    = 1'b1;
            pending_in = 1'b0;
         end else if (!status.empty) begin
            pop        = 1'b1;
            valid_in   = 1'b1;
            out_in     = head_rec.ev0;
            last_in    = !head_rec.second;
            pending_in = head_rec.second;
            sec_in     = head_rec.ev1;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         pending_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         pending_ff <= pending_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      last_ff <= last_in;
      sec_ff  <= sec_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_event_kind   = out_ff.kind;
   assign rsp_name_offset  = out_ff.name_offset;
   assign rsp_name_length  = out_ff.name_length;
   assign rsp_value_offset = out_ff.value_offset;
   assign rsp_value_length = out_ff.value_length;
   assign rsp_last_of_run  = last_ff;

   a_pending_has_first: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> valid_ff)
      else $error("second event held without a first event on output");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (out_ff.kind == EV_ERROR || out_ff.kind == EV_DONE)) |-> last_ff)
      else $error("error or done event not last of its byte");

   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !last_ff && !rsp_stall) |=> (valid_ff && last_ff))
      else $error("second event of a byte did not follow the first");

endmodule

`default_nettype wire

// File: src/xml_tag_tokenizer.sv
// ============================================================================
// xml_tag_tokenizer
// Markup tag tokenizer: one document byte in, element/attribute/error/done
// events out.
// ============================================================================
// The tokenizer takes one document byte per clock cycle while req_stall is
// low. A parser stage classifies each byte as it is transferred and writes
// the events that the byte causes (none, one or two) as one record into a
// four-entry queue; an output register drains the queue at one event per
// cycle while rsp_stall is low, so the first event of a byte passes through
// the queue and then the output register. A byte that ends an element name
// may cause two events (the element event, then an element end or an
// error) and then occupies the output for both of them; req_stall rises
// only while the queue is full, so input keeps flowing at one byte per
// cycle as long as events are taken at least as fast as they are produced.
// Offsets count from the byte that carries start_of_document and are
// OFFSET_BITS wide internally; the result fields carry their low 16 bits.
// ============================================================================
`default_nettype none

module xml_tag_tokenizer #(
   parameter int OFFSET_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic        req_start_of_document,
   input  wire logic [7:0]  req_char_byte,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [2:0]  rsp_event_kind,
   output      logic [15:0] rsp_name_offset,
   output      logic [15:0] rsp_name_length,
   output      logic [15:0] rsp_value_offset,
   output      logic [15:0] rsp_value_length,
   output      logic        rsp_last_of_run
);
   import xtt_pkg::*;

   logic          accept;
   logic          push;
   logic          pop;
   xtt_rec_type   push_rec;
   xtt_rec_type   head_rec;
   xtt_qstat_type status;

   assign req_stall = status.full;
   assign accept    = req_valid && !req_stall;

   xtt_front #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .start_of_document (req_start_of_document),
      .char_byte         (req_char_byte),
      .push              (push),
      .rec               (push_rec)
   );

   xtt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .status   (status)
   );

   xtt_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_rec         (head_rec),
      .status           (status),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_name_offset  (rsp_name_offset),
      .rsp_name_length  (rsp_name_length),
      .rsp_value_offset (rsp_value_offset),
      .rsp_value_length (rsp_value_length),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

`default_nettype wire

// File: tb/xml_tag_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// xml_tag_tokenizer_tb
// Self-checking bench for the markup tag tokenizer. A queue of document bytes
// (directed cases, random documents, one document that runs to the last
// offset) feeds a valid/stall driver; a token predictor turns every
// transferred byte into expected events, and the monitor checks each
// event transfer against the oldest expected one.
// ----------------------------------------------------------------------------
module xml_tag_tokenizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import xtt_pkg::*;

   localparam logic [15:0] OFFSET_TOP   = 16'hFFFF;
   localparam int          RANDOM_BYTES = 1900;
   localparam int          QUIET_LIMIT  = 2000;
   localparam int          DRAIN_CYCLES = 8;
   localparam int          HOLD_AT_A    = 800;
   localparam int          HOLD_AT_B    = 30000;
   localparam int          HOLD_CYCLES  = 200;

   // predictor parse modes
   localparam logic [3:0] PM_HALTED     = 4'd0;
   localparam logic [3:0] PM_ROOT       = 4'd1;
   localparam logic [3:0] PM_TAG        = 4'd2;
   localparam logic [3:0] PM_NAME       = 4'd3;
   localparam logic [3:0] PM_TAG_CLOSE  = 4'd4;
   localparam logic [3:0] PM_ELEM_END   = 4'd5;
   localparam logic [3:0] PM_ATTRIB     = 4'd6;
   localparam logic [3:0] PM_ATTRIB_EQ  = 4'd7;
   localparam logic [3:0] PM_VAL_BEGIN  = 4'd8;
   localparam logic [3:0] PM_VAL_SINGLE = 4'd9;
   localparam logic [3:0] PM_VAL_DOUBLE = 4'd10;

   // predictor name kinds
   localparam logic [1:0] NK_START = 2'd0;
   localparam logic [1:0] NK_END   = 2'd1;
   localparam logic [1:0] NK_ATTR  = 2'd2;

   typedef struct packed {
      logic       sod;
      logic [7:0] ch;
   } doc_byte_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] name_off;
      logic [15:0] name_len;
      logic [15:0] val_off;
      logic [15:0] val_len;
      logic        last;
   } token_ev_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_start_of_document = 1'b0;
   logic [7:0]  req_char_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_event_kind;
   logic [15:0] rsp_name_offset;
   logic [15:0] rsp_name_length;
   logic [15:0] rsp_value_offset;
   logic [15:0] rsp_value_length;
   logic        rsp_last_of_run;

   doc_byte_type byte_q[$];
   doc_byte_type offered;
   logic [7:0]   doc_buf[$];
   token_ev_type token_q[$];
   token_ev_type byte_evs[$];
   logic         req_taken = 1'b0;
   int           cyc = 0;
   int           quiet_cycles = 0;
   int           hold_left = 0;
   int           fault_count = 0;

   // token predictor state
   logic [3:0]  pm = PM_HALTED;
   logic [1:0]  nk = NK_START;
   logic [15:0] pos, tag_off, tag_len, attr_off, attr_len, val_off;

   xml_tag_tokenizer uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_start_of_document (req_start_of_document),
      .req_char_byte         (req_char_byte),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_event_kind        (rsp_event_kind),
      .rsp_name_offset       (rsp_name_offset),
      .rsp_name_length       (rsp_name_length),
      .rsp_value_offset      (rsp_value_offset),
      .rsp_value_length      (rsp_value_length),
      .rsp_last_of_run       (rsp_last_of_run)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Character classes
   // ------------------------------------------------------------------
   function automatic logic is_blank(input logic [7:0] c);
      return c == 8'd9 || c == 8'd10 || c == 8'd13 || c == 8'd32;
   endfunction

   function automatic logic is_lead(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
   endfunction

   function automatic logic is_tail(input logic [7:0] c);
      return is_lead(c) || (c >= "0" && c <= "9") || c == "-" || c == ".";
   endfunction

   // ------------------------------------------------------------------
   // Token predictor
   // ------------------------------------------------------------------
   function automatic void note_event(input logic [2:0] kind, input logic [15:0] no,
                                      input logic [15:0] nl, input logic [15:0] vo,
                                      input logic [15:0] vl);
      token_ev_type ev;
      ev.kind     = kind;
      ev.name_off = no;
      ev.name_len = nl;
      ev.val_off  = vo;
      ev.val_len  = vl;
      ev.last     = 1'b0;
      if (byte_evs.size() < 2) byte_evs.push_back(ev);
   endfunction

   function automatic void note_error(input logic [15:0] p);
      note_event(EV_ERROR, 16'd0, 16'd0, p, 16'd1);
      pm = PM_HALTED;
   endfunction

   task automatic tokenize_byte(input logic sod, input logic [7:0] c);
      logic [15:0] p;
      logic        again;
      byte_evs.delete();
      if (sod) begin
         pm       = PM_ROOT;
         nk       = NK_START;
         pos      = 16'd0;
         tag_off  = 16'd0;
         tag_len  = 16'd0;
         attr_off = 16'd0;
         attr_len = 16'd0;
         val_off  = 16'd0;
      end else if (pm == PM_HALTED) begin
         return;
      end
      p = pos;
      if (p == OFFSET_TOP) begin
         note_error(p);
      end else begin
         // a byte that ends a name is examined again in the next mode
         do begin
            again = 1'b0;
            case (pm)
               PM_ROOT: begin
                  if (c == CH_NUL) begin
                     note_event(EV_DONE, 16'd0, 16'd0, 16'd0, 16'd0);
                     pm = PM_HALTED;
                  end else if (c == CH_LT) begin
                     pm = PM_TAG;
                  end else if (!is_blank(c)) begin
                     note_error(p);
                  end
               end
               PM_TAG: begin
                  if (c == CH_SLASH) begin
                     pm = PM_ELEM_END;
                  end else if (is_lead(c)) begin
                     tag_off = p;
                     nk      = NK_START;
                     pm      = PM_NAME;
                  end else if (!is_blank(c)) begin
                     note_error(p);
                  end
               end
               PM_ELEM_END: begin
                  if (is_lead(c)) begin
                     tag_off = p;
                     nk      = NK_END;
                     pm      = PM_NAME;
                  end else if (!is_blank(c)) begin
                     note_error(p);
                  end
               end
               PM_NAME: begin
                  if (!is_tail(c)) begin
                     again = 1'b1;
                     case (nk)
                        NK_START: begin
                           tag_len = p - tag_off;
                           note_event(EV_START, tag_off, tag_len, 16'd0, 16'd0);
                           pm = PM_ATTRIB;
                        end
                        NK_END: begin
                           tag_len = p - tag_off;
                           note_event(EV_END, tag_off, tag_len, 16'd0, 16'd0);
                           pm = PM_TAG_CLOSE;
                        end
                        default: begin
                           attr_len = p - attr_off;
                           pm = PM_ATTRIB_EQ;
                        end
                     endcase
                  end
               end
               PM_TAG_CLOSE: begin
                  if (c == CH_GT) pm = PM_ROOT;
                  else note_error(p);
               end
               PM_ATTRIB: begin
                  if (c == CH_SLASH) begin
                     note_event(EV_END, tag_off, tag_len, 16'd0, 16'd0);
                     pm = PM_TAG_CLOSE;
                  end else if (c == CH_GT) begin
                     pm = PM_ROOT;
                  end else if (is_lead(c)) begin
                     attr_off = p;
                     nk       = NK_ATTR;
                     pm       = PM_NAME;
                  end else if (!is_blank(c)) begin
                     note_error(p);
                  end
               end
               PM_ATTRIB_EQ: begin
                  if (c == CH_EQ) pm = PM_VAL_BEGIN;
                  else if (!is_blank(c)) note_error(p);
               end
               PM_VAL_BEGIN: begin
                  if (c == CH_DQ || c == CH_SQ) begin
                     val_off = p + 16'd1;
                     pm = (c == CH_DQ) ? PM_VAL_DOUBLE : PM_VAL_SINGLE;
                  end else if (!is_blank(c)) begin
                     note_error(p);
                  end
               end
               PM_VAL_SINGLE, PM_VAL_DOUBLE: begin
                  if (c < CH_CTRL) begin
                     note_error(p);
                  end else if ((pm == PM_VAL_SINGLE && c == CH_SQ) ||
                               (pm == PM_VAL_DOUBLE && c == CH_DQ)) begin
                     note_event(EV_ATTR, attr_off, attr_len, val_off, p - val_off);
                     pm = PM_ATTRIB;
                  end
               end
               default: pm = PM_HALTED;
            endcase
         end while (again);
      end
      if (pm != PM_HALTED) pos = p + 16'd1;
      if (byte_evs.size() != 0) byte_evs[byte_evs.size() - 1].last = 1'b1;
      foreach (byte_evs[i]) token_q.push_back(byte_evs[i]);
   endtask

   // ------------------------------------------------------------------
   // Event checking
   // ------------------------------------------------------------------
   function automatic void log_fault(input string msg);
      fault_count++;
      if (fault_count <= 10) $display("%0t: %s", $realtime, msg);
   endfunction

   task automatic check_event();
      token_ev_type want;
      if (token_q.size() == 0) begin
         log_fault($sformatf("unexpected event kind=%0d no=%0d nl=%0d vo=%0d vl=%0d last=%0d",
                             rsp_event_kind, rsp_name_offset, rsp_name_length,
                             rsp_value_offset, rsp_value_length, rsp_last_of_run));
         return;
      end
      want = token_q.pop_front();
      if (want.kind !== rsp_event_kind || want.name_off !== rsp_name_offset ||
          want.name_len !== rsp_name_length || want.val_off !== rsp_value_offset ||
          want.val_len !== rsp_value_length || want.last !== rsp_last_of_run) begin
         log_fault($sformatf({"event mismatch: expected kind=%0d no=%0d nl=%0d vo=%0d ",
                              "vl=%0d last=%0d, actual kind=%0d no=%0d nl=%0d vo=%0d ",
                              "vl=%0d last=%0d"},
                             want.kind, want.name_off, want.name_len, want.val_off,
                             want.val_len, want.last, rsp_event_kind, rsp_name_offset,
                             rsp_name_length, rsp_value_offset, rsp_value_length,
                             rsp_last_of_run));
      end
   endtask

   // ------------------------------------------------------------------
   // Document generation
   // ------------------------------------------------------------------
   function automatic logic [7:0] pick_lead();
      case ($urandom_range(0, 2))
         0:       return "A" + 8'($urandom_range(0, 25));
         1:       return "a" + 8'($urandom_range(0, 25));
         default: return "_";
      endcase
   endfunction

   function automatic logic [7:0] pick_tail();
      case ($urandom_range(0, 4))
         0:       return "0" + 8'($urandom_range(0, 9));
         1:       return "-";
         2:       return ".";
         default: return pick_lead();
      endcase
   endfunction

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 3))
         0:       return 8'd9;
         1:       return 8'd10;
         2:       return 8'd13;
         default: return 8'd32;
      endcase
   endfunction

   task automatic add_space(input int lo, input int hi);
      repeat ($urandom_range(lo, hi)) doc_buf.push_back(pick_blank());
   endtask

   task automatic add_name();
      doc_buf.push_back(pick_lead());
      repeat ($urandom_range(0, 3)) doc_buf.push_back(pick_tail());
   endtask

   task automatic add_value(input logic [7:0] quote);
      logic [7:0] c;
      doc_buf.push_back(quote);
      repeat ($urandom_range(0, 4)) begin
         do c = 8'($urandom_range(32, 255)); while (c == quote);
         doc_buf.push_back(c);
      end
      doc_buf.push_back(quote);
   endtask

   // one complete construct between tags: open/empty tag, close tag or blanks
   task automatic add_element();
      case ($urandom_range(0, 3))
         0, 1: begin
            doc_buf.push_back(CH_LT);
            add_space(0, 1);
            add_name();
            repeat ($urandom_range(0, 2)) begin
               add_space(1, 2);
               add_name();
               add_space(0, 1);
               doc_buf.push_back(CH_EQ);
               add_space(0, 1);
               add_value($urandom_range(0, 1) ? CH_SQ : CH_DQ);
            end
            add_space(0, 1);
            if ($urandom_range(0, 1)) doc_buf.push_back(CH_SLASH);
            doc_buf.push_back(CH_GT);
         end
         2: begin
            doc_buf.push_back(CH_LT);
            add_space(0, 1);
            doc_buf.push_back(CH_SLASH);
            add_space(0, 1);
            add_name();
            doc_buf.push_back(CH_GT);
         end
         default: add_space(1, 3);
      endcase
   endtask

   task automatic put_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) doc_buf.push_back(s[i]);
   endtask

   // move the built document to the byte queue, restarting on its first byte
   task automatic flush_doc();
      foreach (doc_buf[i]) byte_q.push_back(doc_byte_type'{i == 0, doc_buf[i]});
      doc_buf.delete();
   endtask

   task automatic gen_doc();
      if ($urandom_range(0, 9) == 0) begin
         // raw noise with random restarts
         repeat ($urandom_range(1, 8))
            byte_q.push_back(doc_byte_type'{1'($urandom_range(0, 1)),
                                            8'($urandom_range(0, 255))});
      end else begin
         repeat ($urandom_range(1, 5)) add_element();
         if ($urandom_range(0, 3) != 0) begin
            doc_buf.push_back(CH_NUL);
            repeat ($urandom_range(0, 2)) doc_buf.push_back(8'($urandom_range(0, 255)));
         end
         // corrupt one byte now and then
         if ($urandom_range(0, 4) == 0)
            doc_buf[$urandom_range(0, doc_buf.size() - 1)] = 8'($urandom_range(0, 255));
         flush_doc();
      end
   endtask

   // ------------------------------------------------------------------
   // Random idling, with stretches where it is off
   // ------------------------------------------------------------------
   function automatic logic may_idle();
      if ((cyc >= 1200 && cyc < 1800) || (cyc >= 20000 && cyc < 28000)) return 1'b0;
      return $urandom_range(0, 99) < 8;
   endfunction

   // ------------------------------------------------------------------
   // Byte driver: advance on transfer, hold while stalled
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (byte_q.size() != 0 && !may_idle()) begin
            offered = byte_q.pop_front();
            req_valid             <= 1'b1;
            req_start_of_document <= offered.sod;
            req_char_byte         <= offered.ch;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Event receiver stall: random, plus long hold-offs to fill the block
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (cyc == HOLD_AT_A || cyc == HOLD_AT_B) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end else begin
         rsp_stall <= may_idle();
      end
   end

   // ------------------------------------------------------------------
   // Monitor: predict on byte transfer, check on event transfer
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) tokenize_byte(req_start_of_document, req_char_byte);
         if (rsp_valid && !rsp_stall) check_event();
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------
   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      int rand_base;

      // byte while halted after reset: ignored
      byte_q.push_back(doc_byte_type'{1'b0, "x"});
      // empty element, uppercase inside the name, start and end on one byte, done
      put_text("<aZ9/>");
      doc_buf.push_back(CH_NUL);
      flush_doc();
      // a single-quoted value holding a double quote, then a control byte in a double-quoted value
      put_text("<_ k='\"' v=\"");
      doc_buf.push_back(8'h1F);
      flush_doc();
      // text content at offset zero with the top byte value
      doc_buf.push_back(8'hFF);
      flush_doc();
      // terminator inside a tag
      doc_buf.push_back(CH_LT);
      doc_buf.push_back(CH_NUL);
      flush_doc();
      // close-tag name ended by a bad byte: element end and error on one byte
      put_text("</a-. x");
      flush_doc();

      // random documents
      rand_base = byte_q.size();
      while (byte_q.size() < rand_base + RANDOM_BYTES) gen_doc();

      // long document: terminator lands on the all-ones offset
      while (doc_buf.size() < int'(OFFSET_TOP) - 64) add_element();
      while (doc_buf.size() < int'(OFFSET_TOP)) doc_buf.push_back(8'd32);
      doc_buf.push_back(CH_NUL);
      flush_doc();
      // one more short document after the long one
      gen_doc();

      // hold reset, then release it on a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // drain
      @(posedge clock);
      while (byte_q.size() != 0 || req_valid || token_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
